// ----- rtl/core/sha512_pkg.sv -----
package sha512_pkg;

  localparam int unsigned Rounds     = 80;
  localparam int unsigned BlockWords = 16;

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StInit,
    StRound,
    StFinal,
    StOut
  } state_e;

  typedef logic [63:0] word_t;

  function automatic word_t round_k(input logic [6:0] t);
    word_t k;
    case (t)
      7'd0:  k = 64'h428a2f98d728ae22; 7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f; 7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538; 7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b; 7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242; 7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; default: k = 64'h6c44198c4a475817;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 64'h6a09e667f3bcc908;
      3'd1: h = 64'hbb67ae8584caa73b;
      3'd2: h = 64'h3c6ef372fe94f82b;
      3'd3: h = 64'ha54ff53a5f1d36f1;
      3'd4: h = 64'h510e527fade682d1;
      3'd5: h = 64'h9b05688c2b3e6c1f;
      3'd6: h = 64'h1f83d9abfb41bd6b;
      default: h = 64'h5be0cd19137e2179;
    endcase
    return h;
  endfunction

endpackage

// ----- rtl/core/sha512_if.sv -----
interface sha512_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] msg_word;
  logic [3:0]  byte_count;
  logic        last;
  modport source (output valid, msg_word, byte_count, last, input ready);
  modport sink   (input valid, msg_word, byte_count, last, output ready);
endinterface

interface sha512_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        last_word;
  modport source (output valid, digest_word, last_word, input ready);
  modport sink   (input valid, digest_word, last_word, output ready);
endinterface

// ----- rtl/core/sha512_hash_engine.sv -----
// channel  dir  payload                          transaction
// in_if    in   msg_word, byte_count, last        valid & ready
// out_if   out  digest_word, last_word            valid & ready
// Words are buffered while idle; no input is taken while a block is hashed.
// A full block takes 80 rounds of four phases each (three schedule-memory
// reads, one window write from round 16 on), plus setup and finish states.
// Padding adds at most one block; the digest leaves in 8 transactions.
// Reset restores the initial hash; output stalls hold the digest word.
module sha512_hash_engine import sha512_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sha512_in_if.sink    in_if,
  sha512_out_if.source out_if
);
  state_e     state_q, state_d;
  word_t      hash_q [8];
  word_t      wv_q [8];
  word_t      wv_nx [8];
  logic [3:0] idx_q;
  logic [63:0] bits_q;
  logic [6:0] t_q;
  logic [1:0] ph_q;
  logic [2:0] oc_q;
  logic       padlast_q;   // pending: 0x80 word still to write
  logic       len_slot_q;  // current block carries the length
  logic       pad_pending_q;
  word_t      w16_q, w15_q, w1_q, w2_q;
  logic       we;
  logic [3:0] waddr, raddr;
  word_t      wdata, rdata, w_cur, s0, s1, wnew;
  logic [3:0] nb;
  logic [63:0] keep, padw, inbits;

  sha512_sched u_sched (
    .clk_i, .wr_en_i(we), .wr_addr_i(waddr), .wr_data_i(wdata),
    .rd_addr_i(raddr), .rd_data_o(rdata)
  );

  // w2_q holds the word of two rounds back; rdata carries w[t-7] in phase 3
  always_comb begin
    s0 = {w15_q[0], w15_q[63:1]} ^ {w15_q[7:0], w15_q[63:8]} ^ (w15_q >> 7);
    s1 = {w2_q[18:0], w2_q[63:19]} ^ {w2_q[60:0], w2_q[63:61]} ^ (w2_q >> 6);
    wnew = w16_q + s0 + rdata + s1;
    w_cur = (t_q < 7'(BlockWords)) ? w16_q : wnew;
  end

  sha512_round u_round (.wv_i(wv_q), .w_i(w_cur), .t_i(t_q), .wv_o(wv_nx));

  always_comb begin
    nb = (in_if.byte_count > 4'd8) ? 4'd8 : in_if.byte_count;
    keep = (nb == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {nb[2:0], 3'b000});
    padw = (!in_if.last || nb == 4'd8) ? in_if.msg_word
         : ((in_if.msg_word & keep) | (64'h8000000000000000 >> {nb[2:0], 3'b000}));
    inbits = in_if.last ? {57'd0, nb, 3'b000} : 64'd64;
  end

  // Padding word to write at idx_q while in StPad
  word_t pad_word;
  always_comb begin
    if (padlast_q) pad_word = 64'h8000000000000000;
    else if (idx_q == 4'd15 && len_slot_q) pad_word = bits_q;
    else pad_word = 64'd0;
  end

  always_comb begin
    state_d = state_q;
    in_if.ready = (state_q == StIdle);
    out_if.valid = (state_q == StOut);
    out_if.digest_word = hash_q[oc_q];
    out_if.last_word = (oc_q == 3'd7);
    we = 1'b0;
    waddr = idx_q;
    wdata = pad_word;
    raddr = t_q[3:0];
    unique case (state_q)
      StIdle: begin
        we = in_if.valid;
        wdata = padw;
      end
      StPad: we = 1'b1;
      StRound: begin
        unique case (ph_q)
          2'd0: raddr = t_q[3:0];
          2'd1: raddr = 4'(t_q + 7'd1);
          2'd2: raddr = 4'(t_q + 7'd9);
          default: raddr = t_q[3:0];
        endcase
        we = (ph_q == 2'd3) && (t_q >= 7'(BlockWords));
        waddr = t_q[3:0];
        wdata = wnew;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q <= '0;
      bits_q <= '0;
      padlast_q <= 1'b0;
      len_slot_q <= 1'b0;
      pad_pending_q <= 1'b0;
      t_q <= '0;
      ph_q <= '0;
      oc_q <= '0;
      for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
    end else begin
      unique case (state_q)
        StIdle: if (in_if.valid) begin
          bits_q <= bits_q + inbits;
          idx_q <= idx_q + 4'd1;
          if (in_if.last) begin
            padlast_q <= (nb == 4'd8);
            len_slot_q <= (nb == 4'd8) ? (idx_q <= 4'd12) : (idx_q <= 4'd13);
            state_q <= (idx_q == 4'd15) ? StInit : StPad;
          end else if (idx_q == 4'd15) begin
            len_slot_q <= 1'b0;
            state_q <= StInit;
          end
        end
        StPad: begin
          padlast_q <= 1'b0;
          idx_q <= idx_q + 4'd1;
          if (idx_q == 4'd15) state_q <= StInit;
        end
        StInit: begin
          for (int i = 0; i < 8; i++) wv_q[i] <= hash_q[i];
          t_q <= '0;
          ph_q <= '0;
          state_q <= StRound;
        end
        StRound: begin
          ph_q <= ph_q + 2'd1;
          unique case (ph_q)
            2'd1: w16_q <= rdata;
            2'd2: w15_q <= rdata;
            default: ;
          endcase
          if (ph_q == 2'd3) begin
            for (int i = 0; i < 8; i++) wv_q[i] <= wv_nx[i];
            w1_q <= w_cur;
            w2_q <= w1_q;
            t_q <= t_q + 7'd1;
            if (t_q == 7'(Rounds - 1)) state_q <= StFinal;
          end
        end
        StFinal: begin
          for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + wv_q[i];
          if (len_slot_q) begin
            oc_q <= '0;
            state_q <= StOut;
          end else if (padlast_q || pad_pending_q) begin
            len_slot_q <= 1'b1;
            state_q <= StPad;
          end else begin
            state_q <= StIdle;
          end
        end
        default: if (out_if.ready) begin
          oc_q <= oc_q + 3'd1;
          if (oc_q == 3'd7) begin
            for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
            bits_q <= '0;
            idx_q <= '0;
            pad_pending_q <= 1'b0;
            len_slot_q <= 1'b0;
            state_q <= StIdle;
          end
        end
      endcase
      if (state_q == StIdle && in_if.valid) pad_pending_q <= in_if.last;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> state_q == StOut)
    else $error("digest shown outside output phase");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound) |-> t_q < 7'(Rounds))
    else $error("round index out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> $stable(oc_q))
    else $error("digest index moved under stall");
endmodule

// ----- rtl/core/sha512_round.sv -----
module sha512_round import sha512_pkg::*; (
  input  word_t      wv_i [8],
  input  word_t      w_i,
  input  logic [6:0] t_i,
  output word_t      wv_o [8]
);
  word_t a, e, s1, ch, s0, mj, t1, t2;
  always_comb begin
    a  = wv_i[0];
    e  = wv_i[4];
    s1 = {e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]};
    ch = (e & wv_i[5]) ^ (~e & wv_i[6]);
    s0 = {a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]};
    mj = (a & wv_i[1]) ^ (a & wv_i[2]) ^ (wv_i[1] & wv_i[2]);
    t1 = wv_i[7] + s1 + ch + round_k(t_i) + w_i;
    t2 = s0 + mj;
    wv_o[0] = t1 + t2;
    wv_o[1] = wv_i[0];
    wv_o[2] = wv_i[1];
    wv_o[3] = wv_i[2];
    wv_o[4] = wv_i[3] + t1;
    wv_o[5] = wv_i[4];
    wv_o[6] = wv_i[5];
    wv_o[7] = wv_i[6];
  end
endmodule

// ----- rtl/core/sha512_sched.sv -----
module sha512_sched import sha512_pkg::*; (
  input  logic       clk_i,
  input  logic       wr_en_i,
  input  logic [3:0] wr_addr_i,
  input  word_t      wr_data_i,
  input  logic [3:0] rd_addr_i,
  output word_t      rd_data_o
);
  // 16-entry schedule window, one write and one registered read per cycle
  word_t mem_q [BlockWords];
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end
endmodule

// ----- verif/tb_sha512_hash_engine.sv -----
`timescale 1ns / 1ps

module tb_sha512_hash_engine import sha512_pkg::*;;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned LongHold   = 2000;
  localparam int unsigned MsgItems   = 360;

  typedef struct packed {
    word_t digest_word;
    logic  last_word;
  } digest_exp_t;

  logic clk_i;
  logic rst_ni;

  sha512_in_if  in_bus ();
  sha512_out_if out_bus ();

  sha512_hash_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  word_t       chain_q[8];
  word_t       sched_q[16];
  int unsigned fill_q;
  logic [63:0] nbits_q;

  digest_exp_t digest_fifo[$];
  int unsigned failures;
  int unsigned items_sent;
  int unsigned cycles;
  int unsigned burst_left;
  bit          hold_req;
  int unsigned hold_left;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress_block();
    word_t v[8];
    word_t w, t1, t2, s0, s1;
    for (int i = 0; i < 8; i++) v[i] = chain_q[i];
    for (int t = 0; t < Rounds; t++) begin
      if (t < BlockWords) begin
        w = sched_q[t];
      end else begin
        s0 = rotr(sched_q[(t - 15) & 15], 1) ^ rotr(sched_q[(t - 15) & 15], 8)
             ^ (sched_q[(t - 15) & 15] >> 7);
        s1 = rotr(sched_q[(t - 2) & 15], 19) ^ rotr(sched_q[(t - 2) & 15], 61)
             ^ (sched_q[(t - 2) & 15] >> 6);
        w = sched_q[t & 15] + s0 + sched_q[(t - 7) & 15] + s1;
        sched_q[t & 15] = w;
      end
      t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(t[6:0]) + w;
      t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_q[i] = chain_q[i] + v[i];
  endtask

  task automatic load_word(word_t w);
    sched_q[fill_q] = w;
    fill_q++;
    if (fill_q == BlockWords) begin
      compress_block();
      fill_q = 0;
    end
  endtask

  task automatic init_digest();
    for (int i = 0; i < 8; i++) chain_q[i] = init_hash(i[2:0]);
    fill_q  = 0;
    nbits_q = '0;
  endtask

  task automatic absorb_word(word_t w, logic [3:0] bc, logic lst);
    int unsigned n;
    word_t       keep;
    digest_exp_t e;
    if (!lst) begin
      nbits_q = nbits_q + 64;
      load_word(w);
    end else begin
      n = (bc > 8) ? 8 : bc;
      nbits_q = nbits_q + 8 * n;
      if (n == 8) begin
        load_word(w);
        load_word(64'h8000000000000000);
      end else begin
        keep = (n == 0) ? '0 : ({64{1'b1}} << (64 - 8 * n));
        load_word((w & keep) | (word_t'(8'h80) << (56 - 8 * n)));
      end
      if (fill_q > BlockWords - 2) begin
        while (fill_q != 0) load_word('0);
      end
      while (fill_q < BlockWords - 2) load_word('0);
      load_word('0);
      load_word(nbits_q);
      for (int i = 0; i < 8; i++) begin
        e.digest_word = chain_q[i];
        e.last_word   = (i == 7);
        digest_fifo.push_back(e);
      end
      init_digest();
    end
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_word(word_t w, logic [3:0] bc, logic lst);
    in_bus.valid      <= 1'b1;
    in_bus.msg_word   <= w;
    in_bus.byte_count <= bc;
    in_bus.last       <= lst;
    do @(posedge clk_i); while (!in_bus.ready);
    absorb_word(w, bc, lst);
    items_sent++;
    if (burst_left == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_message(int unsigned full_words, logic [3:0] tail_bc);
    for (int i = 0; i < full_words; i++) send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
    send_word(rand_word(), tail_bc, 1'b1);
  endtask

  task automatic test_empty_message();
    send_word('0, 4'd0, 1'b1);
    send_word('1, 4'd0, 1'b1);
  endtask

  task automatic test_byte_counts();
    for (int n = 1; n <= 8; n++) send_word((n % 2) ? '1 : rand_word(), 4'(n), 1'b1);
  endtask

  task automatic test_count_saturation();
    send_word(rand_word(), 4'd9, 1'b1);
    send_word('1, 4'd15, 1'b1);
  endtask

  task automatic test_nonlast_ignores_count();
    send_word('1, 4'd0, 1'b0);
    send_word(rand_word(), 4'd5, 1'b1);
    send_word('0, 4'd3, 1'b0);
    send_word('1, 4'd8, 1'b1);
  endtask

  task automatic test_random_messages();
    int unsigned len;
    while (items_sent < MsgItems) begin
      case ($urandom_range(0, 9))
        0, 1:    len = $urandom_range(12, 17);
        2:       len = $urandom_range(28, 33);
        default: len = $urandom_range(0, 6);
      endcase
      send_message(len, 4'($urandom_range(0, 15)));
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    burst_left = 200;
    send_message(20, 4'd4);
    send_message(3, 4'd8);
    send_message(0, 4'd0);
  endtask

  // receiver: pattern windows plus one long hold on request of the backpressure test
  initial begin
    int unsigned mode;
    int unsigned phase;
    out_bus.ready <= 1'b0;
    phase = 0;
    mode  = 0;
    forever begin
      @(posedge clk_i);
      if (phase == 0) mode = $urandom_range(0, 2);
      phase = (phase + 1) % 48;
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHold;
        out_bus.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= $urandom_range(0, 1);
          default: out_bus.ready <= (phase % 4 == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    digest_exp_t e;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (digest_fifo.size() == 0) begin
        $error("unexpected digest transaction %h", out_bus.digest_word);
        failures++;
      end else begin
        e = digest_fifo.pop_front();
        if (out_bus.digest_word !== e.digest_word) begin
          $error("digest_word expected %h actual %h", e.digest_word, out_bus.digest_word);
          failures++;
        end
        if (out_bus.last_word !== e.last_word) begin
          $error("last_word expected %b actual %b", e.last_word, out_bus.last_word);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    failures   = 0;
    items_sent = 0;
    cycles     = 0;
    burst_left = 4;
    hold_req   = 1'b0;
    hold_left  = 0;
    init_digest();
    rst_ni = 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.msg_word   <= '0;
    in_bus.byte_count <= '0;
    in_bus.last       <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_message();
    test_byte_counts();
    test_count_saturation();
    test_nonlast_ignores_count();
    test_random_messages();
    test_backpressure();
    test_random_messages();

    in_bus.valid <= 1'b0;
    while (digest_fifo.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
